// File: rtl/core/qkvud_pkg.sv
// Shared types, character codes and a helper function for the query key/value URL decoder.
// Used by qkvud_parser, qkvud_out_fifo and query_key_value_url_decoder. Depends on nothing.
package qkvud_pkg;

    // Port and storage sizes fixed by the register and field definitions.
    localparam int CfgDataWidth    = 64;
    localparam int KeyLenWidth     = 4;
    localparam int DefaultKeyBytes = 8;
    localparam int OutFifoDepth    = 4;

    // Configuration register indexes.
    localparam logic CFG_KEY_BYTES  = 1'b0;
    localparam logic CFG_KEY_LENGTH = 1'b1;

    // Characters with a special meaning in a form-encoded query.
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // What one query byte produces: an optional data byte, then an optional terminator.
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       end_valid;
        logic       end_found;
    } qkvud_res_t;

    // One result beat as it leaves the block.
    typedef struct packed {
        logic [7:0] value_byte;
        logic       byte_valid;
        logic       found;
        logic       last;
    } qkvud_item_t;

    // Hex digit decode: bit 4 is set for a valid digit, bits 3..0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// File: rtl/core/qkvud_parser.sv
// Pair/key/value parser: per-byte state update and result generation for one query byte.
// Depends on qkvud_pkg.
module qkvud_parser #(
    parameter int KEY_BYTES = qkvud_pkg::DefaultKeyBytes
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step_en,
    input  logic [7:0]                          in_byte,
    input  logic                                in_end,
    input  logic [KEY_BYTES*8-1:0]              key_bytes,
    input  logic [qkvud_pkg::KeyLenWidth-1:0]   key_length,
    output qkvud_pkg::qkvud_res_t               res,
    output logic                                answer_given
);
    import qkvud_pkg::*;

    localparam int KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam logic [KeyLenWidth-1:0] KEY_BYTES_W = KeyLenWidth'(KEY_BYTES);
    localparam logic [KeyLenWidth-1:0] POS_MAX = {KeyLenWidth{1'b1}};

    localparam logic [1:0] PH_START   = 2'd0;
    localparam logic [1:0] PH_KEY     = 2'd1;
    localparam logic [1:0] PH_VALUE   = 2'd2;
    localparam logic [1:0] PH_SKIP    = 2'd3;

    logic [1:0]             phase_reg, phase_next;
    logic [KeyLenWidth-1:0] pos_reg, pos_next;
    logic                   mis_reg, mis_next;
    logic [1:0]             esc_reg, esc_next;
    logic [7:0]             escv_reg, escv_next;
    logic                   esci_reg, esci_next;
    logic                   ans_reg, ans_next;

    // Key character compare, shared by the key phase and the first key byte of a pair.
    logic [KeyLenWidth-1:0] kc_pos;
    logic                   kc_mis_in;
    logic                   kc_mis;
    logic [KeyLenWidth-1:0] kc_pos_inc;
    logic [7:0]             kc_key_byte;
    logic                   match_cur;
    logic                   match_nx;
    logic [4:0]             hex;
    logic [7:0]             esc_out;

    assign kc_pos    = (phase_reg == PH_START) ? '0 : pos_reg;
    assign kc_mis_in = (phase_reg == PH_START) ? 1'b0 : mis_reg;
    assign kc_key_byte = key_bytes[kc_pos[KIW-1:0]*8 +: 8];
    assign kc_mis = kc_mis_in || (kc_pos >= key_length) || (kc_pos >= KEY_BYTES_W) ||
                    (kc_key_byte != in_byte);
    assign kc_pos_inc = (kc_pos < POS_MAX) ? kc_pos + 1'b1 : kc_pos;

    assign match_cur = !mis_reg && (key_length != '0) && (key_length <= KEY_BYTES_W) &&
                       (pos_reg == key_length);
    assign hex = hex_digit(in_byte);
    assign esc_out = esci_reg ? 8'd0 : escv_reg;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        mis_next   = mis_reg;
        esc_next   = esc_reg;
        escv_next  = escv_reg;
        esci_next  = esci_reg;
        ans_next   = ans_reg;
        res        = '0;
        match_nx   = 1'b0;

        if (!ans_reg) begin
            unique case (phase_reg)
                PH_START, PH_KEY: begin
                    if (phase_reg == PH_START && (in_byte == CHAR_AMP || in_byte == CHAR_EQ)) begin
                        phase_next = PH_START;
                    end else if (in_byte == CHAR_AMP) begin
                        if (match_cur) begin
                            res.end_valid = 1'b1;
                            res.end_found = 1'b1;
                            ans_next      = 1'b1;
                        end else begin
                            phase_next = PH_START;
                        end
                    end else if (in_byte == CHAR_EQ) begin
                        phase_next = match_cur ? PH_VALUE : PH_SKIP;
                    end else begin
                        phase_next = PH_KEY;
                        mis_next   = kc_mis;
                        pos_next   = kc_pos_inc;
                    end
                end
                PH_VALUE: begin
                    if (in_byte == CHAR_AMP) begin
                        // Flush a cut-short escape, then close the answer.
                        if (esc_reg != 2'd0) begin
                            res.data_valid = 1'b1;
                            res.data_byte  = esc_out;
                            esc_next  = 2'd0;
                            escv_next = 8'd0;
                            esci_next = 1'b0;
                        end
                        res.end_valid = 1'b1;
                        res.end_found = 1'b1;
                        ans_next      = 1'b1;
                    end else if (esc_reg == 2'd1) begin
                        if (!hex[4]) begin
                            esci_next = 1'b1;
                        end else begin
                            escv_next = {4'd0, hex[3:0]};
                        end
                        esc_next = 2'd2;
                    end else if (esc_reg == 2'd2) begin
                        res.data_valid = 1'b1;
                        if (esci_reg) begin
                            res.data_byte = 8'd0;
                        end else if (hex[4]) begin
                            res.data_byte = {escv_reg[3:0], hex[3:0]};
                        end else begin
                            res.data_byte = escv_reg;
                        end
                        esc_next  = 2'd0;
                        escv_next = 8'd0;
                        esci_next = 1'b0;
                    end else if (in_byte == CHAR_PLUS) begin
                        res.data_valid = 1'b1;
                        res.data_byte  = CHAR_SPACE;
                    end else if (in_byte == CHAR_PCT) begin
                        esc_next  = 2'd1;
                        escv_next = 8'd0;
                        esci_next = 1'b0;
                    end else begin
                        res.data_valid = 1'b1;
                        res.data_byte  = in_byte;
                    end
                end
                default: begin
                    if (in_byte == CHAR_AMP) begin
                        phase_next = PH_START;
                    end
                end
            endcase
        end

        if (in_end) begin
            if (!ans_next) begin
                match_nx = !mis_next && (key_length != '0) && (key_length <= KEY_BYTES_W) &&
                           (pos_next == key_length);
                res.end_valid = 1'b1;
                if (phase_next == PH_KEY && match_nx) begin
                    res.end_found = 1'b1;
                end else if (phase_next == PH_VALUE) begin
                    if (esc_next != 2'd0) begin
                        res.data_valid = 1'b1;
                        res.data_byte  = esci_next ? 8'd0 : escv_next;
                    end
                    res.end_found = 1'b1;
                end
            end
            // The query is over: all parse state goes back to its reset value for the next query.
            phase_next = PH_START;
            pos_next   = '0;
            mis_next   = 1'b0;
            esc_next   = 2'd0;
            escv_next  = 8'd0;
            esci_next  = 1'b0;
            ans_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            pos_reg   <= '0;
            mis_reg   <= 1'b0;
            esc_reg   <= 2'd0;
            escv_reg  <= 8'd0;
            esci_reg  <= 1'b0;
            ans_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            mis_reg   <= mis_next;
            esc_reg   <= esc_next;
            escv_reg  <= escv_next;
            esci_reg  <= esci_next;
            ans_reg   <= ans_next;
        end
    end

    assign answer_given = ans_reg;

endmodule

// File: rtl/core/qkvud_out_fifo.sv
// Small result queue that takes up to two beats per cycle and gives one per cycle.
// Depends on qkvud_pkg.
module qkvud_out_fifo #(
    parameter int DEPTH = qkvud_pkg::OutFifoDepth
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [1:0]               push_cnt,
    input  qkvud_pkg::qkvud_item_t   push_a,
    input  qkvud_pkg::qkvud_item_t   push_b,
    input  logic                     pop,
    output qkvud_pkg::qkvud_item_t   head,
    output logic                     not_empty,
    output logic                     room2,
    output logic [$clog2(DEPTH):0]   level
);
    import qkvud_pkg::*;

    localparam int PW = $clog2(DEPTH);

    qkvud_item_t      mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic [PW-1:0]    wr_ptr_b;
    logic             do_pop;

    assign do_pop      = pop && (count_reg != '0);
    assign wr_ptr_b    = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + PW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PW'(do_pop);
    assign count_next  = count_reg + (PW+1)'(push_cnt) - (PW+1)'(do_pop);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push_a;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_b] <= push_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room2     = (count_reg <= (PW+1)'(DEPTH - 2));
    assign level     = count_reg;

endmodule

// File: rtl/core/query_key_value_url_decoder.sv
// Top level of the query key/value URL decoder: input register, configuration registers,
// parser and result queue. Depends on qkvud_pkg, qkvud_parser and qkvud_out_fifo.
//
//  Channel   | Direction | Beat contents (lowest bit first)
//  ----------+-----------+------------------------------------------------------------
//  s_*       | in        | tdata: in_byte[7:0]; tlast: end_of_query
//  m_*       | out       | tdata: value_byte[7:0]; tuser: byte_valid, found; tlast: last
//  cfg_*     | in        | index 0: key_bytes (64 bits), index 1: key_length (4 bits)
//
// Each accepted byte is parsed from the input register once the queue has room for two
// beats, so the block sustains one query byte per clock while that room lasts. A byte
// gives at most two result beats (a data byte plus the terminator); the four-entry result
// queue absorbs them and the output side drains one beat per clock. Reset is synchronous
// and active low; it clears the parser state and both configuration registers and empties
// the queue. When m_tready is held low the queue fills and s_tready drops until room returns.
module query_key_value_url_decoder #(
    parameter int KEY_BYTES = qkvud_pkg::DefaultKeyBytes
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // [7:0] in_byte
    input  logic                                  s_tlast,   // end_of_query

    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata,   // [7:0] value_byte
    output logic [1:0]                            m_tuser,   // [0] byte_valid, [1] found
    output logic                                  m_tlast,   // last

    input  logic                                  cfg_we,
    input  logic                                  cfg_addr,
    input  logic [qkvud_pkg::CfgDataWidth-1:0]    cfg_wdata
);
    import qkvud_pkg::*;

    localparam int LW = $clog2(OutFifoDepth) + 1;

    // Configuration registers. Only the key bytes that can ever be compared are stored.
    logic [KEY_BYTES*8-1:0]  key_bytes_reg;
    logic [KeyLenWidth-1:0]  key_length_reg;

    // Input register: holds one query byte until the parser can take it.
    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    in_end_reg;

    qkvud_res_t              res;
    logic                    answer_given;
    logic                    proc_fire;
    logic                    s_fire;

    qkvud_item_t             push_a, push_b, head;
    logic [1:0]              push_cnt;
    logic                    fifo_not_empty;
    logic                    fifo_room2;
    logic [LW-1:0]           fifo_level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_bytes_reg  <= '0;
            key_length_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_KEY_BYTES:  key_bytes_reg  <= cfg_wdata[KEY_BYTES*8-1:0];
                CFG_KEY_LENGTH: key_length_reg <= cfg_wdata[KeyLenWidth-1:0];
                default: ;
            endcase
        end
    end

    // The held byte is parsed only when the queue can take both possible result beats.
    assign proc_fire = in_valid_reg && fifo_room2;
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    qkvud_parser #(
        .KEY_BYTES (KEY_BYTES)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (proc_fire),
        .in_byte      (in_byte_reg),
        .in_end       (in_end_reg),
        .key_bytes    (key_bytes_reg),
        .key_length   (key_length_reg),
        .res          (res),
        .answer_given (answer_given)
    );

    // A data beat always comes before the terminator of the same byte.
    always_comb begin
        push_a = '0;
        push_b = '0;
        push_b.found = res.end_found;
        push_b.last  = 1'b1;
        if (res.data_valid) begin
            push_a.value_byte = res.data_byte;
            push_a.byte_valid = 1'b1;
        end else begin
            push_a.found = res.end_found;
            push_a.last  = 1'b1;
        end
        if (!proc_fire) begin
            push_cnt = 2'd0;
        end else begin
            push_cnt = {1'b0, res.data_valid} + {1'b0, res.end_valid};
        end
    end

    qkvud_out_fifo #(
        .DEPTH (OutFifoDepth)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push_a    (push_a),
        .push_b    (push_b),
        .pop       (m_tready),
        .head      (head),
        .not_empty (fifo_not_empty),
        .room2     (fifo_room2),
        .level     (fifo_level)
    );

    assign m_tvalid = fifo_not_empty;
    assign m_tdata  = head.value_byte;
    assign m_tuser  = {head.found, head.byte_valid};
    assign m_tlast  = head.last;

    // The queue never holds more beats than it has entries.
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_level <= LW'(OutFifoDepth))
        else $error("result queue overflow");

    // Every query ends in exactly one terminator: the final byte gives one unless it came earlier.
    a_one_terminator: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_end_reg && !answer_given |-> res.end_valid)
        else $error("query ended without a terminator");

    // No second terminator and no further data once the answer is out.
    a_no_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && answer_given |-> !res.end_valid && !res.data_valid)
        else $error("result after the answer was given");

    // The end of a query leaves the parser ready for a new one.
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire && in_end_reg |=> !answer_given)
        else $error("answer flag survived the end of the query");

endmodule

// File: tb/tb.sv
// Self-checking testbench for query_key_value_url_decoder: looks up a key in query strings
// sent byte by byte and checks every result beat against an internal predictor.
// Depends on qkvud_pkg and the query_key_value_url_decoder RTL only.
`timescale 1ns / 1ps

module tb;
    import qkvud_pkg::*;

    // The predictor walks the same pair/key/value phases that the block does.
    typedef enum logic [1:0] {
        PH_PAIR_START,
        PH_KEY,
        PH_VALUE,
        PH_SKIP
    } parse_phase_t;

    localparam int KeyBytes = DefaultKeyBytes;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;

    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [7:0]              s_tdata = 8'd0;   // [7:0] in_byte
    logic                    s_tlast = 1'b0;   // end_of_query

    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [7:0]              m_tdata;          // [7:0] value_byte
    logic [1:0]              m_tuser;          // [0] byte_valid, [1] found
    logic                    m_tlast;          // last

    logic                    cfg_we = 1'b0;
    logic                    cfg_addr = CFG_KEY_BYTES;
    logic [CfgDataWidth-1:0] cfg_wdata = '0;

    // Percentage of cycles in which the sender holds back and the receiver stalls.
    int                      idle_pct = 23;
    int                      err_count = 0;
    int                      sent_count = 0;

    // Result beats predicted but not yet seen on the master side, oldest first.
    qkvud_item_t             decoded_beats[$];
    // Query string under construction, sent as one run of beats by send_query.
    logic [7:0]              query_buf[$];

    // Predictor copy of the key registers and of the parse state.
    logic [63:0]             want_key = '0;
    logic [3:0]              want_len = '0;
    parse_phase_t            ph = PH_PAIR_START;
    int                      key_pos = 0;
    bit                      key_bad = 1'b0;
    int                      esc_digits = 0;
    logic [7:0]              esc_val = 8'd0;
    bit                      esc_bad = 1'b0;
    bit                      answered = 1'b0;

    query_key_value_url_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    // Hex digit value, or -1 when the byte is not a hex digit.
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return int'(c - "0");
        end
        if (c >= "a" && c <= "f") begin
            return int'(c - "a") + 10;
        end
        if (c >= "A" && c <= "F") begin
            return int'(c - "A") + 10;
        end
        return -1;
    endfunction

    function automatic bit key_hit();
        return !key_bad && want_len != 0 && want_len <= KeyBytes && key_pos == want_len;
    endfunction

    function automatic void push_data(input logic [7:0] v);
        qkvud_item_t r;
        r = '{value_byte: v, byte_valid: 1'b1, found: 1'b0, last: 1'b0};
        decoded_beats.push_back(r);
    endfunction

    // The terminator closes the answer for this query; later bytes are ignored.
    function automatic void push_end(input bit hit);
        qkvud_item_t r;
        r = '{value_byte: 8'd0, byte_valid: 1'b0, found: hit, last: 1'b1};
        decoded_beats.push_back(r);
        answered = 1'b1;
    endfunction

    // An escape cut short emits the digits seen so far, or zero if the first was bad.
    function automatic void flush_escape();
        if (esc_digits != 0) begin
            push_data(esc_bad ? 8'd0 : esc_val);
            esc_digits = 0;
            esc_val = 8'd0;
            esc_bad = 1'b0;
        end
    endfunction

    function automatic void clear_parse();
        ph = PH_PAIR_START;
        key_pos = 0;
        key_bad = 1'b0;
        esc_digits = 0;
        esc_val = 8'd0;
        esc_bad = 1'b0;
        answered = 1'b0;
    endfunction

    // Advances the predicted parse by one accepted query byte and queues its results.
    function automatic void decode_query_byte(input logic [7:0] b, input logic eoq);
        int         d;
        logic [7:0] v;
        d = hex_nibble(b);
        if (!answered) begin
            // The first byte that is neither a separator nor '=' opens the key.
            if (ph == PH_PAIR_START && b != CHAR_AMP && b != CHAR_EQ) begin
                ph = PH_KEY;
                key_pos = 0;
                key_bad = 1'b0;
            end
            case (ph)
                PH_KEY: begin
                    if (b == CHAR_AMP) begin
                        // A key with no '=' still matches, with an empty value.
                        if (key_hit()) begin
                            push_end(1'b1);
                        end else begin
                            ph = PH_PAIR_START;
                        end
                    end else if (b == CHAR_EQ) begin
                        ph = key_hit() ? PH_VALUE : PH_SKIP;
                    end else begin
                        if (key_pos >= want_len || key_pos >= KeyBytes) begin
                            key_bad = 1'b1;
                        end else if (want_key[8*key_pos +: 8] != b) begin
                            key_bad = 1'b1;
                        end
                        if (key_pos < 15) begin
                            key_pos++;
                        end
                    end
                end
                PH_VALUE: begin
                    if (b == CHAR_AMP) begin
                        flush_escape();
                        push_end(1'b1);
                    end else if (esc_digits == 1) begin
                        if (d < 0) begin
                            esc_bad = 1'b1;
                        end else begin
                            esc_val = 8'(d);
                        end
                        esc_digits = 2;
                    end else if (esc_digits == 2) begin
                        // A bad second digit keeps the first digit's value on its own.
                        if (esc_bad) begin
                            v = 8'd0;
                        end else if (d >= 0) begin
                            v = {esc_val[3:0], 4'(d)};
                        end else begin
                            v = esc_val;
                        end
                        push_data(v);
                        esc_digits = 0;
                        esc_val = 8'd0;
                        esc_bad = 1'b0;
                    end else if (b == CHAR_PLUS) begin
                        push_data(CHAR_SPACE);
                    end else if (b == CHAR_PCT) begin
                        esc_digits = 1;
                        esc_val = 8'd0;
                        esc_bad = 1'b0;
                    end else begin
                        push_data(b);
                    end
                end
                PH_SKIP: begin
                    if (b == CHAR_AMP) begin
                        ph = PH_PAIR_START;
                    end
                end
                default: begin
                end
            endcase
        end
        if (eoq) begin
            if (!answered) begin
                if (ph == PH_KEY && key_hit()) begin
                    push_end(1'b1);
                end else if (ph == PH_VALUE) begin
                    flush_escape();
                    push_end(1'b1);
                end else begin
                    push_end(1'b0);
                end
            end
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------------------------------
    // Result side: random back-pressure and the beat checker
    // ------------------------------------------------------------------------------------

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Handshake signals are read right after the edge, before any update of this step
    // lands, so they hold the values that the edge itself sampled.
    always @(posedge aclk) begin : check_beats
        qkvud_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_beats.size() == 0) begin
                $error("result beat with none expected: value_byte %0h tuser %0b last %0b",
                       m_tdata, m_tuser, m_tlast);
                err_count++;
            end else begin
                want = decoded_beats.pop_front();
                if (m_tdata !== want.value_byte) begin
                    $error("value_byte: expected %0h, got %0h", want.value_byte, m_tdata);
                    err_count++;
                end
                if (m_tuser[0] !== want.byte_valid) begin
                    $error("byte_valid: expected %0b, got %0b", want.byte_valid, m_tuser[0]);
                    err_count++;
                end
                if (m_tuser[1] !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, m_tuser[1]);
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------------------

    // Sends one query byte. Valid is left high on return so that back-to-back beats never
    // see valid lowered and raised in the same step; the idle loop lowers it.
    task automatic send_beat(input logic [7:0] b, input logic eoq);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eoq;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        decode_query_byte(b, eoq);
        sent_count++;
    endtask

    task automatic send_query();
        for (int i = 0; i < query_buf.size(); i++) begin
            send_beat(query_buf[i], i == query_buf.size() - 1);
        end
        query_buf.delete();
    endtask

    function automatic void add_byte(input logic [7:0] b);
        query_buf.push_back(b);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            query_buf.push_back(s[i]);
        end
    endfunction

    // Holds the sender back until every predicted beat has arrived. The extra cycles
    // cover bytes after an early terminator, which the block swallows without a result.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (decoded_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);
    endtask

    // Writes both key registers; called only while the block is idle.
    task automatic program_key(input logic [63:0] key, input logic [3:0] len);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_KEY_BYTES;
        cfg_wdata <= key;
        @(posedge aclk);
        cfg_addr  <= CFG_KEY_LENGTH;
        cfg_wdata <= CfgDataWidth'(len);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
        want_key = key;
        want_len = len;
    endtask

    // ------------------------------------------------------------------------------------
    // Random query generation
    // ------------------------------------------------------------------------------------

    // Any byte that can sit inside a key, which excludes the separators.
    function automatic logic [7:0] key_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (c == CHAR_AMP || c == CHAR_EQ);
        return c;
    endfunction

    function automatic logic [63:0] random_key();
        logic [63:0] k;
        for (int i = 0; i < 8; i++) begin
            k[8*i +: 8] = key_char();
        end
        return k;
    endfunction

    // Mostly valid hex digits, sometimes the bytes just outside each digit range.
    function automatic logic [7:0] hex_char();
        string good;
        string bad;
        good = "0123456789abcdefABCDEF";
        bad  = "/:@G`g";
        if ($urandom_range(9) < 8) begin
            return good[$urandom_range(good.len() - 1)];
        end
        return bad[$urandom_range(bad.len() - 1)];
    endfunction

    function automatic void add_value_token();
        case ($urandom_range(9))
            0, 1, 2, 3: add_byte(8'($urandom_range("a", "z")));
            4: add_byte(CHAR_PLUS);
            5, 6: begin
                add_byte(CHAR_PCT);
                add_byte(hex_char());
                add_byte(hex_char());
            end
            7: add_byte(CHAR_EQ);
            8: add_byte(8'($urandom_range(255)));
            default: begin
                // An escape that the next separator or the end of the query may cut short.
                add_byte(CHAR_PCT);
                if ($urandom_range(1) == 1) begin
                    add_byte(hex_char());
                end
            end
        endcase
    endfunction

    // Builds a query that is mostly well-formed pairs around the programmed key, with
    // near misses, empty pairs and stray '=' mixed in, and now and then pure noise.
    function automatic void add_random_query();
        int npairs;
        int kind;
        int n;
        int flip;
        if ($urandom_range(99) < 8) begin
            n = $urandom_range(1, 10);
            repeat (n) add_byte(8'($urandom_range(255)));
            return;
        end
        npairs = $urandom_range(1, 4);
        for (int i = 0; i < npairs; i++) begin
            if (i > 0) begin
                add_byte(CHAR_AMP);
            end
            if ($urandom_range(99) < 12) begin
                add_byte(CHAR_AMP);
            end
            if ($urandom_range(99) < 10) begin
                repeat ($urandom_range(1, 2)) add_byte(CHAR_EQ);
            end
            kind = $urandom_range(9);
            flip = (want_len > 0) ? $urandom_range(int'(want_len) - 1) : 0;
            if (kind <= 7) begin
                // Exact key, or a prefix, an extension, or one corrupted byte of it.
                n = (kind == 5) ? int'(want_len) - 1 : int'(want_len);
                for (int j = 0; j < n; j++) begin
                    if (kind == 7 && j == flip) begin
                        add_byte(want_key[8*j +: 8] ^ 8'($urandom_range(1, 255)));
                    end else begin
                        add_byte(want_key[8*j +: 8]);
                    end
                end
                if (kind == 6) begin
                    add_byte(key_char());
                end
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 3)) add_byte(key_char());
            end
            if ($urandom_range(99) < 85) begin
                add_byte(CHAR_EQ);
                n = $urandom_range(0, 6);
                repeat (n) add_value_token();
            end
        end
        // A query must hold at least one byte.
        if (query_buf.size() == 0) begin
            add_byte(CHAR_AMP);
        end
    endfunction

    // ------------------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------------------

    // Plus to space, upper and lower case escapes, a bad first and a bad second digit,
    // then bytes after the terminator that must be ignored. The second query cuts an
    // escape short with '&' before any digit has arrived.
    task automatic test_value_decoding();
        program_key({48'd0, "d", "i"}, 4'd2);
        add_text("id=+%41%6a%zz%4z&x");
        send_query();
        add_text("id=%&x=y");
        send_query();
    endtask

    // Empty pairs, a pair of only '=', a key prefix and a longer key, then a bare key
    // at the end of the query. Next: a leading '=', an extra '=' in the value and an
    // escape cut short by the end of the query; a bare key ended by '&'; and a query
    // without the key whose final byte is NUL.
    task automatic test_pair_shapes();
        add_text("==&&i=1&idx=2&id");
        send_query();
        add_text("=id=a=b%4");
        send_query();
        add_text("id&id=z");
        send_query();
        add_text("a=b");
        add_byte(8'h00);
        send_query();
    endtask

    // Longest key with bytes at both ends of the range, then an empty key, which must
    // never match, and a single-byte key.
    task automatic test_key_extremes();
        wait_drained();
        program_key(64'h01FE_3CC3_7F80_FF00, 4'd8);
        for (int i = 0; i < 8; i++) begin
            add_byte(want_key[8*i +: 8]);
        end
        add_byte(CHAR_EQ);
        add_byte(8'hFF);
        add_byte(8'h00);
        send_query();
        wait_drained();
        program_key(64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        add_text("x=1&x");
        send_query();
        wait_drained();
        program_key({56'd0, "k"}, 4'd1);
        add_text("kk=1&k");
        send_query();
    endtask

    // Random queries under one key setting. Now and then the sender waits for every
    // expected beat before it goes on.
    task automatic run_random_phase(input logic [63:0] key, input logic [3:0] len,
                                    input int byte_goal);
        int phase_start;
        wait_drained();
        program_key(key, len);
        phase_start = sent_count;
        while (sent_count - phase_start < byte_goal) begin
            add_random_query();
            send_query();
            if ($urandom_range(99) < 5) begin
                wait_drained();
            end
        end
    endtask

    task automatic test_random_queries();
        run_random_phase(random_key(), 4'd8, 150);
        run_random_phase(random_key(), 4'd1, 150);
        run_random_phase(random_key(), 4'd0, 120);
        run_random_phase(random_key(), 4'($urandom_range(2, 7)), 150);
    endtask

    // Same traffic with neither side ever holding back, to run the block at full rate.
    task automatic test_full_rate();
        wait_drained();
        idle_pct = 0;
        run_random_phase(random_key(), 4'd3, 150);
        wait_drained();
        idle_pct = 23;
    endtask

    // ------------------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------------------

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_value_decoding();
        test_pair_shapes();
        test_key_extremes();
        test_random_queries();
        test_full_rate();

        wait_drained();
        if (err_count == 0 && decoded_beats.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // The slowest correct run stays far below this bound.
    initial begin
        #4_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
